### hdl/slpss_pkg.sv
// Shared types, codes and command helpers for the panel scan sequencer.
// No dependencies; used by slpss_step and sensor_led_panel_scan_sequencer_core.
`default_nettype none

package slpss_pkg;

    localparam int SENSOR_COUNT = 48;
    localparam int SLOT_W       = $clog2(SENSOR_COUNT);
    localparam int MAX_RESULTS  = 5;
    localparam int COUNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int PATTERN_W    = 48;

    localparam logic [7:0] ADC_CTRL_BASE = 8'b10001111;
    localparam logic [7:0] EMIT_ONE_HOT  = 8'h01;
    localparam logic [1:0] LEN_ADC       = 2'd3;
    localparam logic [1:0] LEN_SHORT     = 2'd2;

    // Chip-select codes, bit0 is sel0
    typedef enum logic [3:0] {
        SC_ADC0 = 4'b0000,
        SC_ADC1 = 4'b0001,
        SC_ADC2 = 4'b0010,
        SC_ADC3 = 4'b0011,
        SC_ADC4 = 4'b0100,
        SC_ADC5 = 4'b0101,
        SC_LED0 = 4'b1000,
        SC_LED1 = 4'b1001,
        SC_LED2 = 4'b1010,
        SC_EMIT = 4'b1011
    } scan_code_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte_one;
        logic [7:0] rx_byte_two;
    } event_word_t;

    typedef struct packed {
        logic [3:0]        select_code;
        logic              emitter_out_off;
        logic              indicator_out_off;
        logic              sample_valid;
        logic [SLOT_W-1:0] sample_index;
        logic [7:0]        sample_value;
        logic              send_valid;
        logic [1:0]        send_length;
        logic [23:0]       send_bytes;
        logic              cycle_done;
        logic              last;
    } result_word_t;

    typedef struct packed {
        scan_code_t scan;
        logic [2:0] sensor_index;
        logic       running;
        logic [3:0] select_lines;
        logic       emitter_off;
        logic       indicator_off;
    } scan_state_t;

    // Pin lines seen after one pin write
    typedef struct packed {
        logic [3:0] select_code;
        logic       emitter_off;
        logic       indicator_off;
    } pin_snap_t;

    // Fields carried only by the final word of a burst
    typedef struct packed {
        logic              sample_valid;
        logic [SLOT_W-1:0] sample_index;
        logic [7:0]        sample_value;
        logic              send_valid;
        logic [1:0]        send_length;
        logic [23:0]       send_bytes;
        logic              cycle_done;
    } tail_t;

    typedef struct packed {
        pin_snap_t [MAX_RESULTS-1:0] snaps;
        logic [COUNT_W-1:0]          count;
        tail_t                       tail;
    } burst_t;

    function automatic pin_snap_t mk_snap(logic [3:0] sel, logic eo, logic io);
        pin_snap_t s;
        s.select_code   = sel;
        s.emitter_off   = eo;
        s.indicator_off = io;
        return s;
    endfunction

    // Command for the selected device: {length, bytes}
    function automatic logic [25:0] build_cmd(scan_code_t scan, logic [2:0] idx,
                                              logic [PATTERN_W-1:0] pattern);
        logic [7:0] ctrl;
        logic [7:0] hot;
        logic [25:0] cmd;
        ctrl = ADC_CTRL_BASE | {1'b0, idx[0], idx[2], idx[1], 4'b0000};
        hot  = EMIT_ONE_HOT << idx;
        case (scan)
            SC_ADC0, SC_ADC1, SC_ADC2, SC_ADC3, SC_ADC4, SC_ADC5:
                cmd = {LEN_ADC, ctrl, 16'h0000};
            SC_LED0: cmd = {LEN_SHORT, pattern[15:8], pattern[7:0], 8'h00};
            SC_LED1: cmd = {LEN_SHORT, pattern[31:24], pattern[23:16], 8'h00};
            SC_LED2: cmd = {LEN_SHORT, pattern[47:40], pattern[39:32], 8'h00};
            default: cmd = {LEN_SHORT, hot, hot, 8'h00};
        endcase
        return cmd;
    endfunction

endpackage

`default_nettype wire

### hdl/sensor_led_panel_scan_sequencer_core.sv
// Top level of the panel scan sequencer: state, pattern register and burst buffer.
// Depends on slpss_pkg and slpss_step.
//
//   channel   dir  handshake                    payload
//   event     in   event_valid / event_stall    event_word  (slpss_pkg::event_word_t)
//   result    out  result_valid / result_stall  result_word (slpss_pkg::result_word_t)
//   pattern   in   pattern_we                   pattern_wdata (48 bits)
//
// An event is worked out in the cycle it is accepted; its 1 to 5 result words
// leave from the burst buffer, starting the next cycle, one word per cycle while
// result_stall is low. A new event is taken in the cycle the last word of the
// previous burst leaves. Reset (rst_n, async, low) selects the emitter code, raises
// all select lines and both disables, clears the pattern and empties the buffer.
// result_stall holds the current word; event_stall rises while a burst is pending.
`default_nettype none

module sensor_led_panel_scan_sequencer_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  event_valid,
    output logic                                  event_stall,
    input  slpss_pkg::event_word_t                event_word,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output slpss_pkg::result_word_t               result_word,
    input  logic                                  pattern_we,
    input  logic [slpss_pkg::PATTERN_W-1:0]       pattern_wdata
);

    slpss_pkg::scan_state_t                          state_reg;
    slpss_pkg::scan_state_t                          state_next;
    slpss_pkg::burst_t                               burst;
    logic [slpss_pkg::PATTERN_W-1:0]                 pattern_reg;
    slpss_pkg::pin_snap_t [slpss_pkg::MAX_RESULTS-1:0] snaps_reg;
    slpss_pkg::pin_snap_t [slpss_pkg::MAX_RESULTS-1:0] snaps_next;
    logic [slpss_pkg::COUNT_W-1:0]                   count_reg;
    logic [slpss_pkg::COUNT_W-1:0]                   count_next;
    slpss_pkg::tail_t                                tail_reg;
    slpss_pkg::tail_t                                tail_next;
    logic                                            ev_fire;
    logic                                            res_fire;
    logic                                            on_last;

    slpss_step u_step (
        .cur_state (state_reg),
        .ev        (event_word),
        .pattern   (pattern_reg),
        .nxt_state (state_next),
        .burst     (burst)
    );

    assign on_last      = (count_reg == slpss_pkg::COUNT_W'(1));
    assign result_valid = (count_reg != '0);
    assign res_fire     = result_valid && !result_stall;
    assign event_stall  = result_valid && !(res_fire && on_last);
    assign ev_fire      = event_valid && !event_stall;

    always_comb
    begin
        result_word                   = '0;
        result_word.select_code       = snaps_reg[0].select_code;
        result_word.emitter_out_off   = snaps_reg[0].emitter_off;
        result_word.indicator_out_off = snaps_reg[0].indicator_off;
        result_word.last              = on_last;
        if (on_last)
        begin
            result_word.sample_valid = tail_reg.sample_valid;
            result_word.sample_index = tail_reg.sample_index;
            result_word.sample_value = tail_reg.sample_value;
            result_word.send_valid   = tail_reg.send_valid;
            result_word.send_length  = tail_reg.send_length;
            result_word.send_bytes   = tail_reg.send_bytes;
            result_word.cycle_done   = tail_reg.cycle_done;
        end
    end

    always_comb
    begin
        snaps_next = snaps_reg;
        count_next = count_reg;
        tail_next  = tail_reg;
        if (ev_fire)
        begin
            snaps_next = burst.snaps;
            count_next = burst.count;
            tail_next  = burst.tail;
        end
        else if (res_fire)
        begin
            for (int i = 0; i < slpss_pkg::MAX_RESULTS - 1; i++)
            begin
                snaps_next[i] = snaps_reg[i+1];
            end
            snaps_next[slpss_pkg::MAX_RESULTS-1] = '0;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.scan          <= slpss_pkg::SC_EMIT;
            state_reg.sensor_index  <= '0;
            state_reg.running       <= 1'b0;
            state_reg.select_lines  <= 4'b1111;
            state_reg.emitter_off   <= 1'b1;
            state_reg.indicator_off <= 1'b1;
            pattern_reg             <= '0;
            count_reg               <= '0;
        end
        else
        begin
            if (ev_fire)
            begin
                state_reg <= state_next;
            end
            if (pattern_we)
            begin
                pattern_reg <= pattern_wdata;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snaps_reg <= snaps_next;
        tail_reg  <= tail_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= slpss_pkg::COUNT_W'(slpss_pkg::MAX_RESULTS))
        else $error("burst count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        ev_fire |=> result_valid)
        else $error("accepted event left no result word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !on_last) |-> event_stall)
        else $error("event taken while a burst is still pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_word.cycle_done) |->
            (result_word.last && !result_word.send_valid))
        else $error("cycle done on a word that sends or is not last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_word.sample_valid) |-> result_word.last)
        else $error("sample reported before the last word");
`endif

endmodule

`default_nettype wire

### hdl/slpss_step.sv
// Single-pass step logic: one event word and the current scan state give the
// next state and the whole burst of pin-write words. Depends on slpss_pkg.
`default_nettype none

module slpss_step (
    input  slpss_pkg::scan_state_t                    cur_state,
    input  slpss_pkg::event_word_t                    ev,
    input  logic [slpss_pkg::PATTERN_W-1:0]           pattern,
    output slpss_pkg::scan_state_t                    nxt_state,
    output slpss_pkg::burst_t                         burst
);

    logic [3:0]                          sel;
    logic                                eo;
    logic                                io;
    logic [slpss_pkg::COUNT_W-1:0]       n;
    logic                                is_adc;
    logic [25:0]                         cmd;

    assign is_adc = cur_state.scan inside {slpss_pkg::SC_ADC0, slpss_pkg::SC_ADC1,
                                           slpss_pkg::SC_ADC2, slpss_pkg::SC_ADC3,
                                           slpss_pkg::SC_ADC4, slpss_pkg::SC_ADC5};

    always_comb
    begin
        nxt_state = cur_state;
        burst     = '0;
        sel       = cur_state.select_lines;
        eo        = cur_state.emitter_off;
        io        = cur_state.indicator_off;
        n         = '0;
        cmd       = '0;

        if (!ev.mode)
        begin
            // start: both disables merged into the first word, then four pin writes
            nxt_state.scan         = slpss_pkg::SC_EMIT;
            nxt_state.sensor_index = '0;
            nxt_state.running      = 1'b1;
            eo = 1'b1;
            io = 1'b1;
            burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
            sel[0] = 1'b1; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
            sel[1] = 1'b1; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
            sel[2] = 1'b0; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
            sel[3] = 1'b1; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
            cmd = slpss_pkg::build_cmd(nxt_state.scan, nxt_state.sensor_index, pattern);
            burst.tail.send_valid  = 1'b1;
            burst.tail.send_length = cmd[25:24];
            burst.tail.send_bytes  = cmd[23:0];
        end
        else
        begin
            if (is_adc)
            begin
                burst.tail.sample_valid = 1'b1;
                burst.tail.sample_value = {ev.rx_byte_one[5:0], ev.rx_byte_two[7:6]};
                burst.tail.sample_index = {cur_state.scan[2:0], cur_state.sensor_index};
                if (cur_state.scan == slpss_pkg::SC_ADC4)
                begin
                    nxt_state.sensor_index = cur_state.sensor_index + 3'd1;
                end
            end
            else if (cur_state.scan == slpss_pkg::SC_LED0)
            begin
                io = 1'b0;
                burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
            end
            else if (cur_state.scan != slpss_pkg::SC_LED2 &&
                     cur_state.scan != slpss_pkg::SC_LED1)
            begin
                eo = 1'b0;
                burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                io = 1'b1;
                burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
            end

            // walk the select code, one line per write
            case (cur_state.scan)
                slpss_pkg::SC_ADC0:
                begin
                    sel[0] = 1'b1; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    nxt_state.scan = slpss_pkg::SC_ADC1;
                end
                slpss_pkg::SC_ADC1:
                begin
                    sel[1] = 1'b1; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    nxt_state.scan = slpss_pkg::SC_ADC3;
                end
                slpss_pkg::SC_ADC3:
                begin
                    sel[0] = 1'b0; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    nxt_state.scan = slpss_pkg::SC_ADC2;
                end
                slpss_pkg::SC_ADC2:
                begin
                    sel[2] = 1'b1; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    sel[0] = 1'b1; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    sel[1] = 1'b0; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    nxt_state.scan = slpss_pkg::SC_ADC5;
                end
                slpss_pkg::SC_ADC5:
                begin
                    sel[0] = 1'b0; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    nxt_state.scan = slpss_pkg::SC_ADC4;
                end
                slpss_pkg::SC_ADC4:
                begin
                    sel[3] = 1'b1; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    sel[0] = 1'b1; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    sel[1] = 1'b1; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    nxt_state.scan = slpss_pkg::SC_EMIT;
                end
                slpss_pkg::SC_LED2:
                begin
                    sel[0] = 1'b0; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    sel[2] = 1'b0; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    sel[2] = 1'b1; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    sel[0] = 1'b1; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    sel[1] = 1'b0; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    nxt_state.scan = slpss_pkg::SC_LED1;
                end
                slpss_pkg::SC_LED1:
                begin
                    sel[2] = 1'b0; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    sel[2] = 1'b1; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    sel[0] = 1'b0; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    nxt_state.scan = slpss_pkg::SC_LED0;
                end
                slpss_pkg::SC_LED0:
                begin
                    sel[2] = 1'b0; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    sel[3] = 1'b0; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    nxt_state.scan = slpss_pkg::SC_ADC0;
                end
                default:
                begin
                    // emitter code, and any code that cannot occur
                    sel[2] = 1'b0; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    sel[2] = 1'b1; burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                    nxt_state.scan = slpss_pkg::SC_LED2;
                end
            endcase

            if (nxt_state.scan == slpss_pkg::SC_EMIT && nxt_state.sensor_index == 3'd0)
            begin
                nxt_state.running     = 1'b0;
                burst.tail.cycle_done = 1'b1;
            end
            else if (cur_state.running)
            begin
                if (nxt_state.scan == slpss_pkg::SC_EMIT)
                begin
                    eo = 1'b1;
                    burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io); n = n + 1'b1;
                end
                cmd = slpss_pkg::build_cmd(nxt_state.scan, nxt_state.sensor_index, pattern);
                burst.tail.send_valid  = 1'b1;
                burst.tail.send_length = cmd[25:24];
                burst.tail.send_bytes  = cmd[23:0];
            end
        end

        // every event yields at least one word
        if (n == '0)
        begin
            burst.snaps[n] = slpss_pkg::mk_snap(sel, eo, io);
            n = n + 1'b1;
        end

        nxt_state.select_lines  = sel;
        nxt_state.emitter_off   = eo;
        nxt_state.indicator_off = io;
        burst.count             = n;
    end

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the panel scan sequencer core.
// Depends on slpss_pkg and the core; predicts each result word and compares in order.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic        MODE_START   = 1'b0;
    localparam logic        MODE_DONE    = 1'b1;
    localparam int          PHASES       = 5;
    localparam int          RANDOM_ITEMS = 430;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned PRESSURE_LEN = 150;

    logic                            clk;
    logic                            rst_n         = 1'b0;
    logic                            event_valid   = 1'b0;
    logic                            event_stall;
    slpss_pkg::event_word_t          event_word    = '0;
    logic                            result_valid;
    logic                            result_stall  = 1'b0;
    slpss_pkg::result_word_t         result_word;
    logic                            pattern_we    = 1'b0;
    logic [slpss_pkg::PATTERN_W-1:0] pattern_wdata = '0;

    sensor_led_panel_scan_sequencer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .event_valid   (event_valid),
        .event_stall   (event_stall),
        .event_word    (event_word),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_word   (result_word),
        .pattern_we    (pattern_we),
        .pattern_wdata (pattern_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Shadow copy of the sequencer state
    slpss_pkg::scan_code_t           m_scan;
    logic [2:0]                      m_idx;
    logic                            m_running;
    logic [3:0]                      m_sel;
    logic                            m_eo;
    logic                            m_io;
    logic [slpss_pkg::PATTERN_W-1:0] m_pattern;

    slpss_pkg::result_word_t burst_buf [slpss_pkg::MAX_RESULTS];
    int                      burst_len;

    slpss_pkg::event_word_t  event_backlog [$];
    slpss_pkg::result_word_t expected_words [$];

    int          fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    logic        offering = 1'b0;
    int unsigned recv_gap = 0;
    int unsigned hold_left = 0;
    logic        pressure_done = 1'b0;
    logic        stall_next;
    int unsigned words_seen = 0;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Stretches with no idling on either side
    function automatic logic calm_stretch();
        return (cycle_count % 600) < 150;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic void snap_pins();
        slpss_pkg::result_word_t r;
        r                   = '0;
        r.select_code       = m_sel;
        r.emitter_out_off   = m_eo;
        r.indicator_out_off = m_io;
        if (burst_len < slpss_pkg::MAX_RESULTS)
        begin
            burst_buf[burst_len] = r;
            burst_len++;
        end
    endfunction

    function automatic void write_pin(int sel_line, logic val);
        m_sel[sel_line] = val;
        snap_pins();
    endfunction

    // One select line per pin write, unused codes as stepping stones
    function automatic void step_select();
        case (m_scan)
            slpss_pkg::SC_ADC0:
            begin
                write_pin(0, 1'b1);
                m_scan = slpss_pkg::SC_ADC1;
            end
            slpss_pkg::SC_ADC1:
            begin
                write_pin(1, 1'b1);
                m_scan = slpss_pkg::SC_ADC3;
            end
            slpss_pkg::SC_ADC3:
            begin
                write_pin(0, 1'b0);
                m_scan = slpss_pkg::SC_ADC2;
            end
            slpss_pkg::SC_ADC2:
            begin
                write_pin(2, 1'b1);
                write_pin(0, 1'b1);
                write_pin(1, 1'b0);
                m_scan = slpss_pkg::SC_ADC5;
            end
            slpss_pkg::SC_ADC5:
            begin
                write_pin(0, 1'b0);
                m_scan = slpss_pkg::SC_ADC4;
            end
            slpss_pkg::SC_ADC4:
            begin
                write_pin(3, 1'b1);
                write_pin(0, 1'b1);
                write_pin(1, 1'b1);
                m_scan = slpss_pkg::SC_EMIT;
            end
            slpss_pkg::SC_LED2:
            begin
                write_pin(0, 1'b0);
                write_pin(2, 1'b0);
                write_pin(2, 1'b1);
                write_pin(0, 1'b1);
                write_pin(1, 1'b0);
                m_scan = slpss_pkg::SC_LED1;
            end
            slpss_pkg::SC_LED1:
            begin
                write_pin(2, 1'b0);
                write_pin(2, 1'b1);
                write_pin(0, 1'b0);
                m_scan = slpss_pkg::SC_LED0;
            end
            slpss_pkg::SC_LED0:
            begin
                write_pin(2, 1'b0);
                write_pin(3, 1'b0);
                m_scan = slpss_pkg::SC_ADC0;
            end
            default:
            begin
                write_pin(2, 1'b0);
                write_pin(2, 1'b1);
                m_scan = slpss_pkg::SC_LED2;
            end
        endcase
    endfunction

    // {length, bytes} of the command for the selected device
    function automatic logic [25:0] next_command();
        logic [7:0]  ctrl;
        logic [7:0]  hot;
        int unsigned k;
        ctrl    = slpss_pkg::ADC_CTRL_BASE;
        ctrl[6] = m_idx[0];
        ctrl[4] = m_idx[1];
        ctrl[5] = m_idx[2];
        hot     = slpss_pkg::EMIT_ONE_HOT << m_idx;
        case (m_scan)
            slpss_pkg::SC_ADC0, slpss_pkg::SC_ADC1, slpss_pkg::SC_ADC2,
            slpss_pkg::SC_ADC3, slpss_pkg::SC_ADC4, slpss_pkg::SC_ADC5:
                return {slpss_pkg::LEN_ADC, ctrl, 16'h0000};
            slpss_pkg::SC_LED0, slpss_pkg::SC_LED1, slpss_pkg::SC_LED2:
            begin
                // driver k gets byte 2k+1 first, then byte 2k
                k = int'(m_scan) - int'(slpss_pkg::SC_LED0);
                return {slpss_pkg::LEN_SHORT, m_pattern[16*k+8 +: 8],
                        m_pattern[16*k +: 8], 8'h00};
            end
            default:
                return {slpss_pkg::LEN_SHORT, hot, hot, 8'h00};
        endcase
    endfunction

    function automatic void predict_event(slpss_pkg::event_word_t w);
        logic [25:0]                  cmd;
        logic                         send;
        logic                         done;
        logic                         sampled;
        logic [slpss_pkg::SLOT_W-1:0] sidx;
        logic [7:0]                   sval;
        slpss_pkg::result_word_t      r;
        burst_len = 0;
        cmd       = '0;
        send      = 1'b0;
        done      = 1'b0;
        sampled   = 1'b0;
        sidx      = '0;
        sval      = '0;
        if (w.mode == MODE_START)
        begin
            m_scan    = slpss_pkg::SC_EMIT;
            m_idx     = '0;
            m_running = 1'b1;
            m_eo      = 1'b1;
            m_io      = 1'b1;
            // both disables merged into the first word
            snap_pins();
            write_pin(0, 1'b1);
            write_pin(1, 1'b1);
            write_pin(2, 1'b0);
            write_pin(3, 1'b1);
            cmd  = next_command();
            send = 1'b1;
        end
        else
        begin
            if (m_scan <= slpss_pkg::SC_ADC5)
            begin
                sampled = 1'b1;
                sval    = {w.rx_byte_one[5:0], w.rx_byte_two[7:6]};
                sidx    = {m_scan[2:0], m_idx};
                if (m_scan == slpss_pkg::SC_ADC4)
                    m_idx = m_idx + 3'd1;
            end
            else if (m_scan == slpss_pkg::SC_LED0)
            begin
                m_io = 1'b0;
                snap_pins();
            end
            else if (m_scan != slpss_pkg::SC_LED2 && m_scan != slpss_pkg::SC_LED1)
            begin
                m_eo = 1'b0;
                snap_pins();
                m_io = 1'b1;
                snap_pins();
            end
            step_select();
            if (m_scan == slpss_pkg::SC_EMIT && m_idx == 3'd0)
            begin
                m_running = 1'b0;
                done      = 1'b1;
            end
            else if (m_running)
            begin
                if (m_scan == slpss_pkg::SC_EMIT)
                begin
                    m_eo = 1'b1;
                    snap_pins();
                end
                cmd  = next_command();
                send = 1'b1;
            end
        end
        if (burst_len == 0)
            snap_pins();
        r              = burst_buf[burst_len-1];
        r.sample_valid = sampled;
        r.sample_index = sidx;
        r.sample_value = sval;
        r.send_valid   = send;
        r.send_length  = send ? cmd[25:24] : 2'd0;
        r.send_bytes   = send ? cmd[23:0] : 24'd0;
        r.cycle_done   = done;
        r.last         = 1'b1;
        burst_buf[burst_len-1] = r;
        for (int i = 0; i < burst_len; i++)
            expected_words.push_back(burst_buf[i]);
    endfunction

    function automatic void check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Driver: offers words from the backlog, holds each until taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (event_valid && !event_stall)
            begin
                predict_event(event_word);
                send_gap = calm_stretch() ? 0 : pick_gap();
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (event_backlog.size() > 0)
                begin
                    event_word <= event_backlog.pop_front();
                    offering = 1'b1;
                end
            end
            event_valid <= offering;
        end
    end

    // Monitor: compares each taken word with the oldest prediction, drives stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none actual %0h",
                             $time, result_word);
                    fail_count++;
                end
                else
                begin
                    slpss_pkg::result_word_t e;
                    e = expected_words.pop_front();
                    check_field("select_code", 24'(e.select_code),
                                24'(result_word.select_code));
                    check_field("emitter_out_off", 24'(e.emitter_out_off),
                                24'(result_word.emitter_out_off));
                    check_field("indicator_out_off", 24'(e.indicator_out_off),
                                24'(result_word.indicator_out_off));
                    check_field("sample_valid", 24'(e.sample_valid),
                                24'(result_word.sample_valid));
                    check_field("sample_index", 24'(e.sample_index),
                                24'(result_word.sample_index));
                    check_field("sample_value", 24'(e.sample_value),
                                24'(result_word.sample_value));
                    check_field("send_valid", 24'(e.send_valid),
                                24'(result_word.send_valid));
                    check_field("send_length", 24'(e.send_length),
                                24'(result_word.send_length));
                    check_field("send_bytes", e.send_bytes, result_word.send_bytes);
                    check_field("cycle_done", 24'(e.cycle_done),
                                24'(result_word.cycle_done));
                    check_field("last", 24'(e.last), 24'(result_word.last));
                end
                words_seen++;
                recv_gap = calm_stretch() ? 0 : pick_gap();
            end
            else if (recv_gap > 0)
                recv_gap--;
            // one long hold-off so the burst buffer fills and the input backs up
            if (!pressure_done && words_seen >= 120)
            begin
                hold_left     = PRESSURE_LEN;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else
                stall_next = (recv_gap != 0);
            result_stall <= stall_next;
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((event_valid && !event_stall) || (result_valid && !result_stall) || pattern_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic slpss_pkg::event_word_t make_event(logic mode, logic [7:0] b1,
                                                          logic [7:0] b2);
        slpss_pkg::event_word_t w;
        w.mode        = mode;
        w.rx_byte_one = b1;
        w.rx_byte_two = b2;
        return w;
    endfunction

    function automatic slpss_pkg::event_word_t random_done();
        return make_event(MODE_DONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endfunction

    task automatic queue_directed();
        logic [7:0] b1 [10];
        logic [7:0] b2 [10];
        b1 = '{8'hFF, 8'h00, 8'h80, 8'h3F, 8'hFF, 8'h00, 8'hC0, 8'h01, 8'h7F, 8'hAA};
        b2 = '{8'hFF, 8'h00, 8'hC0, 8'h3F, 8'h00, 8'hFF, 8'h40, 8'h80, 8'hFE, 8'h55};
        // exchange-done words before any start: no command goes out
        event_backlog.push_back(make_event(MODE_DONE, 8'h00, 8'h00));
        event_backlog.push_back(make_event(MODE_DONE, 8'hFF, 8'hFF));
        // one full round: emitter, three LED drivers, six ADCs
        event_backlog.push_back(make_event(MODE_START, 8'hFF, 8'hFF));
        for (int i = 0; i < 10; i++)
            event_backlog.push_back(make_event(MODE_DONE, b1[i], b2[i]));
        for (int i = 0; i < 3; i++)
            event_backlog.push_back(make_event(MODE_DONE, b1[i], b2[9-i]));
        // restart in the middle of a round
        event_backlog.push_back(make_event(MODE_START, 8'h00, 8'h00));
        event_backlog.push_back(make_event(MODE_DONE, 8'h5A, 8'hA5));
        event_backlog.push_back(make_event(MODE_DONE, 8'hA5, 8'h5A));
    endtask

    // Mostly complete scans of eight rounds, some cut short, some noise;
    // the last group is trimmed so the phase holds exactly target words
    task automatic queue_random(int target);
        int          n;
        int unsigned r;
        int unsigned len;
        n = 0;
        while (n < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                len = (r < 65) ? 80 : $urandom_range(1, 79);
                if (len > unsigned'(target - n - 1))
                    len = unsigned'(target - n - 1);
                event_backlog.push_back(make_event(MODE_START, 8'($urandom_range(0, 255)),
                                                   8'($urandom_range(0, 255))));
                for (int i = 0; i < len; i++)
                    event_backlog.push_back(random_done());
                n += len + 1;
            end
            else
            begin
                len = $urandom_range(1, 8);
                if (len > unsigned'(target - n))
                    len = unsigned'(target - n);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        event_backlog.push_back(make_event(MODE_START,
                                                           8'($urandom_range(0, 255)),
                                                           8'($urandom_range(0, 255))));
                    else
                        event_backlog.push_back(random_done());
                end
                n += len;
            end
        end
    endtask

    task automatic write_pattern(logic [slpss_pkg::PATTERN_W-1:0] v);
        @(posedge clk);
        pattern_we    <= 1'b1;
        pattern_wdata <= v;
        m_pattern      = v;
        @(posedge clk);
        pattern_we    <= 1'b0;
    endtask

    task automatic wait_drained();
        while (event_backlog.size() != 0 || event_valid || expected_words.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [slpss_pkg::PATTERN_W-1:0] patterns [PHASES];
        m_scan    = slpss_pkg::SC_EMIT;
        m_idx     = '0;
        m_running = 1'b0;
        m_sel     = 4'hF;
        m_eo      = 1'b1;
        m_io      = 1'b1;
        m_pattern = '0;
        patterns = '{48'h0123_4567_89AB, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000,
                     48'({$urandom, $urandom}), 48'({$urandom, $urandom})};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_pattern(patterns[ph]);
            @(negedge clk);
            if (ph == 0)
                queue_directed();
            queue_random(RANDOM_ITEMS / PHASES);
            wait_drained();
            repeat (6) @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
